### src/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is not checked while reset is asserted.
`define IPPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ippr assertion failed");

// Property that is checked at every edge, reset included.
`define IPPR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ippr assertion failed");

`endif

### src/ippr_pkg.sv
package ippr_pkg;

  localparam int NUM_IRQ_DEF   = 240;
  localparam int BIT_WORDS_DEF = 8;

  // Register windows, base inclusive and end exclusive.
  localparam logic [11:0] EN_SET_BASE   = 12'h000;
  localparam logic [11:0] EN_SET_END    = 12'h020;
  localparam logic [11:0] EN_CLR_BASE   = 12'h080;
  localparam logic [11:0] EN_CLR_END    = 12'h0A0;
  localparam logic [11:0] PEND_SET_BASE = 12'h100;
  localparam logic [11:0] PEND_SET_END  = 12'h120;
  localparam logic [11:0] PEND_CLR_BASE = 12'h180;
  localparam logic [11:0] PEND_CLR_END  = 12'h1A0;
  localparam logic [11:0] PRIO_BASE     = 12'h300;
  localparam logic [11:0] PRIO_END      = 12'h500;

  localparam int LANES      = 4;
  localparam int PRIO_ROW_W = 7;
  localparam int LANE_ROW_W = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNALIGNED = 2'd1,
    ST_UNMAPPED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WIDTH_BYTE = 2'd0,
    WIDTH_HALF = 2'd1,
    WIDTH_WORD = 2'd2
  } width_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Decoded request. bit_sel and prio_rd are only set when the status is ok.
  typedef struct packed {
    status_t                 status;
    logic                    is_write;
    logic                    bit_sel;
    logic                    bit_clear;
    logic                    bit_pend;
    logic [2:0]              bit_word;
    logic                    prio_rd;
    logic [PRIO_ROW_W-1:0]   prio_row;
  } req_t;

  // Per-lane priority byte writes.
  typedef struct packed {
    logic [LANES-1:0]                  en;
    logic [LANES-1:0][LANE_ROW_W-1:0]  row;
    logic [LANES-1:0][7:0]             data;
  } prio_wr_t;

endpackage

### src/ippr_if.sv
interface req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [11:0] offset;
  logic [31:0] write_data;
  logic [1:0]  access_width;

  modport source (output valid, output operation, output offset, output write_data,
                  output access_width, input ready);
  modport sink (input valid, input operation, input offset, input write_data,
                input access_width, output ready);
endinterface

interface rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink (input valid, input read_data, input status, output ready);
endinterface

### src/ippr_decode.sv
module ippr_decode import ippr_pkg::*; #(
  parameter int NUM_IRQ   = NUM_IRQ_DEF,
  parameter int BIT_WORDS = BIT_WORDS_DEF
) (
  input  logic        operation,
  input  logic [11:0] offset,
  input  logic [31:0] write_data,
  input  logic [1:0]  access_width,
  output req_t        req,
  output prio_wr_t    pwr
);

  localparam int ROWS = (NUM_IRQ + 3) / 4;

  always_comb begin
    logic        is_wr;
    logic        wc_bad;
    logic        is_word;
    logic        in_prio;
    logic        win_es;
    logic        win_ec;
    logic        win_ps;
    logic        win_pc;
    logic        bit_hit;
    logic        prio_map;
    logic [11:0] pofs;
    logic [1:0]  i;
    logic [9:0]  bidx;
    logic        len_ok;

    is_wr   = (operation == OP_WRITE);
    wc_bad  = !(access_width == WIDTH_BYTE || access_width == WIDTH_HALF ||
                access_width == WIDTH_WORD);
    is_word = (access_width == WIDTH_WORD);
    in_prio = (offset >= PRIO_BASE) && (offset < PRIO_END);
    win_es  = (offset >= EN_SET_BASE) && (offset < EN_SET_END);
    win_ec  = (offset >= EN_CLR_BASE) && (offset < EN_CLR_END);
    win_ps  = (offset >= PEND_SET_BASE) && (offset < PEND_SET_END);
    win_pc  = (offset >= PEND_CLR_BASE) && (offset < PEND_CLR_END);
    bit_hit = (win_es || win_ec || win_ps || win_pc) && (int'(offset[4:2]) < BIT_WORDS);
    pofs    = offset - PRIO_BASE;
    prio_map = int'(pofs[8:2]) < ROWS;

    req           = '0;
    req.status    = ST_OK;
    req.is_write  = is_wr;
    req.bit_clear = win_ec || win_pc;
    req.bit_pend  = win_ps || win_pc;
    req.bit_word  = offset[4:2];
    req.prio_row  = pofs[8:2];

    if (wc_bad) begin
      req.status = ST_UNALIGNED;
    end else if (!is_wr) begin
      if (!is_word) begin
        req.status = ST_UNALIGNED;
      end else if (in_prio) begin
        if (prio_map) begin
          req.prio_rd = 1'b1;
        end else begin
          req.status = ST_UNMAPPED;
        end
      end else if (bit_hit) begin
        req.bit_sel = 1'b1;
      end else begin
        req.status = ST_UNMAPPED;
      end
    end else if (!in_prio) begin
      if (!is_word) begin
        req.status = ST_UNALIGNED;
      end else if (bit_hit) begin
        req.bit_sel = 1'b1;
      end else begin
        req.status = ST_UNMAPPED;
      end
    end

    // Byte i of the write data lands in lane (first + i) mod 4.
    pwr = '0;
    for (int l = 0; l < LANES; l++) begin
      i    = 2'(l) - pofs[1:0];
      bidx = {1'b0, pofs[8:0]} + 10'(i);
      case (access_width)
        WIDTH_BYTE: len_ok = (i == 2'd0);
        WIDTH_HALF: len_ok = !i[1];
        WIDTH_WORD: len_ok = 1'b1;
        default:    len_ok = 1'b0;
      endcase
      pwr.en[l]   = is_wr && in_prio && len_ok && (int'(bidx) < NUM_IRQ);
      pwr.row[l]  = bidx[9:2];
      pwr.data[l] = 8'(write_data >> {i, 3'b000});
    end
  end

endmodule

### src/ippr_bit_mem.sv
module ippr_bit_mem #(
  parameter int ENTRIES = 16,
  parameter int ADDR_W  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data
);

  logic [31:0]        mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [31:0]        rd_word;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // Entries that were never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_word : '0;

endmodule

### src/ippr_prio_mem.sv
module ippr_prio_mem import ippr_pkg::*; #(
  parameter int ROWS  = 60,
  parameter int ROW_W = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [ROW_W-1:0]             rd_row,
  output logic [31:0]                  rd_data,
  input  logic [LANES-1:0]             wr_en,
  input  logic [LANES-1:0][ROW_W-1:0]  wr_row,
  input  logic [LANES-1:0][7:0]        wr_data
);

  // One byte-wide memory per lane, so an unaligned write touches each lane once.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [7:0]      mem [ROWS];
    logic [ROWS-1:0] vld;
    logic [7:0]      rd_byte;
    logic            rd_vld;

    always_ff @(posedge clk) begin
      if (wr_en[l]) begin
        mem[wr_row[l]] <= wr_data[l];
      end
      if (rd_en) begin
        rd_byte <= mem[rd_row];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld    <= '0;
        rd_vld <= 1'b0;
      end else begin
        if (wr_en[l]) begin
          vld[wr_row[l]] <= 1'b1;
        end
        if (rd_en) begin
          rd_vld <= vld[rd_row];
        end
      end
    end

    assign rd_data[8*l +: 8] = rd_vld ? rd_byte : 8'h00;
  end

endmodule

### src/interrupt_enable_pending_priority_regs.sv
// Register interface of an interrupt controller. Each request is one bus
// access (read or write, 12-bit byte offset, data, byte/half/word width) and
// produces exactly one response with read data and a status (ok, unaligned
// width, unmapped offset). Enable bits live at 0x000 (set) and 0x080 (clear),
// pending bits at 0x100 (set) and 0x180 (clear); both windows read back the
// current bits and need word-wide accesses. Priority bytes live at 0x300 and
// take byte, half and word writes at any offset; bytes past NUM_IRQ are
// dropped with an ok status, and reads return four bytes per word. The enable
// and pending words sit in one synchronous memory, the priority bytes in four
// byte-lane memories; all reset to zero through per-entry valid bits, so no
// clearing pass is needed and requests are taken right after reset. A request
// issues its memory read when it is accepted, and the execute state then does
// the read-modify-write of the enable or pending word and loads the response
// register once that register is free. No new request is accepted until the
// current one has finished; a held response stalls the request after it in
// the execute state until the response is taken.
module interrupt_enable_pending_priority_regs import ippr_pkg::*; #(
  parameter int NUM_IRQ   = NUM_IRQ_DEF,
  parameter int BIT_WORDS = BIT_WORDS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  req_if.sink   req,
  rsp_if.source rsp
);

  localparam int ROWS        = (NUM_IRQ + 3) / 4;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIT_ENTRIES = 2 * BIT_WORDS;
  localparam int BADDR_W     = $clog2(BIT_ENTRIES);

  state_t                       state;
  state_t                       state_next;
  req_t                         dreq;
  prio_wr_t                     pwr;
  req_t                         req_q;
  logic [31:0]                  wdata_q;
  logic [BADDR_W-1:0]           baddr;
  logic [BADDR_W-1:0]           baddr_q;
  logic                         accept;
  logic                         done;
  logic [31:0]                  bit_rd;
  logic [31:0]                  prio_rd;
  logic                         bit_we;
  logic [31:0]                  bit_wd;
  logic [LANES-1:0][ROW_W-1:0]  lane_row;
  logic                         rsp_valid;
  logic [31:0]                  rsp_data;
  status_t                      rsp_status;

  ippr_decode #(
    .NUM_IRQ   (NUM_IRQ),
    .BIT_WORDS (BIT_WORDS)
  ) u_decode (
    .operation    (req.operation),
    .offset       (req.offset),
    .write_data   (req.write_data),
    .access_width (req.access_width),
    .req          (dreq),
    .pwr          (pwr)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  // The response register must be free before a request can finish.
  assign done      = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  // Enable words come first in the bit memory, pending words after them.
  assign baddr = dreq.bit_pend ? BADDR_W'(BIT_WORDS) + BADDR_W'(dreq.bit_word)
                               : BADDR_W'(dreq.bit_word);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= dreq;
      wdata_q <= req.write_data;
      baddr_q <= baddr;
    end
  end

  // Read-modify-write of an enable or pending word. Only one request is in
  // flight, so the write-back never races a read of the same word.
  assign bit_we = done && req_q.bit_sel && req_q.is_write;
  assign bit_wd = req_q.bit_clear ? (bit_rd & ~wdata_q) : (bit_rd | wdata_q);

  ippr_bit_mem #(
    .ENTRIES (BIT_ENTRIES),
    .ADDR_W  (BADDR_W)
  ) u_bit_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && dreq.bit_sel),
    .rd_addr (baddr),
    .rd_data (bit_rd),
    .wr_en   (bit_we),
    .wr_addr (baddr_q),
    .wr_data (bit_wd)
  );

  // Priority writes need no old data, so they go to the lanes on acceptance.
  for (genvar l = 0; l < LANES; l++) begin : g_row
    assign lane_row[l] = pwr.row[l][ROW_W-1:0];
  end

  ippr_prio_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_prio_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && dreq.prio_rd),
    .rd_row  (dreq.prio_row[ROW_W-1:0]),
    .rd_data (prio_rd),
    .wr_en   (pwr.en & {LANES{accept}}),
    .wr_row  (lane_row),
    .wr_data (pwr.data)
  );

  // Response register: it holds a finished response until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_status <= req_q.status;
      if (req_q.bit_sel && !req_q.is_write) begin
        rsp_data <= bit_rd;
      end else if (req_q.prio_rd) begin
        rsp_data <= prio_rd;
      end else begin
        rsp_data <= '0;
      end
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data;
  assign rsp.status    = rsp_status;

endmodule

### src/ippr_checker.sv
`include "assert_macros.svh"

module ippr_checker import ippr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_read_data,
  input logic [1:0]  rsp_status
);

  // One request at a time: after an acceptance the next cycle takes nothing.
  `IPPR_ASSERT(a_one_in_flight, clk, rst, (req_valid && req_ready) |=> !req_ready)

  // A failed access never returns data.
  `IPPR_ASSERT(a_err_zero_data, clk, rst, (rsp_valid && rsp_status != ST_OK) |-> (rsp_read_data == 32'h0))

  // A held response keeps its payload.
  `IPPR_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data) && $stable(rsp_status)))

  // Reset drops any pending response and leaves the block ready.
  `IPPR_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (!rsp_valid && req_ready))

endmodule

bind interrupt_enable_pending_priority_regs ippr_checker u_ippr_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data),
  .rsp_status    (rsp.status)
);

### test/ippr_register_mirror.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a mirror of the enable, pending and priority
// stores, and compares every response with the one the mirror predicts.
module ippr_register_mirror import ippr_pkg::*; (
  input  logic clk,
  input  logic rst,
  req_if       req,
  rsp_if       rsp,
  output int   failures,
  output int   outstanding,
  output int   responses_checked,
  output int   unaligned_seen,
  output int   unmapped_seen
);

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
  } access_result_t;

  logic [31:0]    enable_words [BIT_WORDS_DEF];
  logic [31:0]    pending_words [BIT_WORDS_DEF];
  logic [7:0]     priority_bytes [NUM_IRQ_DEF];
  access_result_t expected_responses [$];

  // Applies one access to the mirror and returns the response it must give.
  function automatic access_result_t predict_access(input logic op, input logic [11:0] off,
                                                    input logic [31:0] data,
                                                    input logic [1:0] width);
    access_result_t result;
    logic           in_prio;
    logic           bit_hit;
    logic           bit_pend;
    logic           bit_clear;
    logic [11:0]    bit_base;
    int             bit_word;
    int             first;
    int             nbytes;
    result.read_data = '0;
    result.status = ST_OK;
    in_prio = (off >= PRIO_BASE) && (off < PRIO_END);
    bit_hit = 1'b1;
    bit_pend = 1'b0;
    bit_clear = 1'b0;
    bit_base = EN_SET_BASE;
    if (off < EN_SET_END) begin
      bit_base = EN_SET_BASE;
    end else if (off >= EN_CLR_BASE && off < EN_CLR_END) begin
      bit_base = EN_CLR_BASE;
      bit_clear = 1'b1;
    end else if (off >= PEND_SET_BASE && off < PEND_SET_END) begin
      bit_base = PEND_SET_BASE;
      bit_pend = 1'b1;
    end else if (off >= PEND_CLR_BASE && off < PEND_CLR_END) begin
      bit_base = PEND_CLR_BASE;
      bit_pend = 1'b1;
      bit_clear = 1'b1;
    end else begin
      bit_hit = 1'b0;
    end
    bit_word = int'(off - bit_base) / 4;
    if (bit_hit && bit_word >= BIT_WORDS_DEF) bit_hit = 1'b0;

    if (width != WIDTH_BYTE && width != WIDTH_HALF && width != WIDTH_WORD) begin
      result.status = ST_UNALIGNED;
    end else if (op == OP_READ) begin
      if (width != WIDTH_WORD) begin
        result.status = ST_UNALIGNED;
      end else if (in_prio) begin
        first = (int'(off - PRIO_BASE) / 4) * 4;
        if (first >= NUM_IRQ_DEF) begin
          result.status = ST_UNMAPPED;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (first + i < NUM_IRQ_DEF) result.read_data[8*i +: 8] = priority_bytes[first + i];
          end
        end
      end else if (!bit_hit) begin
        result.status = ST_UNMAPPED;
      end else if (bit_pend) begin
        result.read_data = pending_words[bit_word];
      end else begin
        result.read_data = enable_words[bit_word];
      end
    end else if (in_prio) begin
      first = int'(off - PRIO_BASE);
      nbytes = 1 << width;
      for (int i = 0; i < nbytes; i++) begin
        if (first + i < NUM_IRQ_DEF) priority_bytes[first + i] = data[8*i +: 8];
      end
    end else if (width != WIDTH_WORD) begin
      result.status = ST_UNALIGNED;
    end else if (!bit_hit) begin
      result.status = ST_UNMAPPED;
    end else if (bit_pend) begin
      pending_words[bit_word] = bit_clear ? (pending_words[bit_word] & ~data)
                                          : (pending_words[bit_word] | data);
    end else begin
      enable_words[bit_word] = bit_clear ? (enable_words[bit_word] & ~data)
                                         : (enable_words[bit_word] | data);
    end
    return result;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      foreach (enable_words[i]) enable_words[i] = '0;
      foreach (pending_words[i]) pending_words[i] = '0;
      foreach (priority_bytes[i]) priority_bytes[i] = '0;
      expected_responses.delete();
      failures = 0;
      responses_checked = 0;
      unaligned_seen = 0;
      unmapped_seen = 0;
    end else begin
      // A response can never belong to a request taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        responses_checked++;
        if (rsp.status == ST_UNALIGNED) unaligned_seen++;
        if (rsp.status == ST_UNMAPPED) unmapped_seen++;
        if (expected_responses.size() == 0) begin
          failures++;
          $display("%0t: unexpected response, expected none, got read_data %h status %0d",
                   $time, rsp.read_data, rsp.status);
        end else begin
          want = expected_responses.pop_front();
          if (rsp.status != want.status) begin
            failures++;
            $display("%0t: status mismatch, expected %s, got %0d",
                     $time, want.status.name(), rsp.status);
          end
          if (rsp.read_data != want.read_data) begin
            failures++;
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want.read_data, rsp.read_data);
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_responses.push_back(predict_access(req.operation, req.offset,
                                                    req.write_data, req.access_width));
      end
    end
    outstanding = expected_responses.size();
  end

endmodule

### test/interrupt_enable_pending_priority_regs_test.sv
`timescale 1ns / 100ps

// Top of the register interface test. It only makes stimulus: requests on
// the request channel, the ready of the response channel, and the verdict.
// Prediction and comparison live in the register mirror beside the block.
module interrupt_enable_pending_priority_regs_test;
  import ippr_pkg::*;

  // The width field has one code with no meaning; the block must flag it.
  localparam logic [1:0] WIDTH_INVALID = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  // Long enough for the response register to fill and the request side to stall.
  localparam int LONG_HOLD = 150;
  localparam int HOLD_REQUESTS = 30;
  localparam int PHASE_ITEMS = 330;
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;

  req_if req();
  rsp_if rsp();

  // Percentages of idle cycles on the request side and stall cycles on the
  // response side, changed by the main process between phases.
  int send_idle_pct;
  int stall_pct;
  // The main process asks for a long response hold by bumping this count; the
  // ready process notices the change and counts the hold out on its own.
  int hold_requests;
  int holds_started;
  int cycle_count;
  int reads_sent;
  int writes_sent;

  int failures;
  int outstanding;
  int responses_checked;
  int unaligned_seen;
  int unmapped_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interrupt_enable_pending_priority_regs dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ippr_register_mirror mirror (
    .clk               (clk),
    .rst               (rst),
    .req               (req),
    .rsp               (rsp),
    .failures          (failures),
    .outstanding       (outstanding),
    .responses_checked (responses_checked),
    .unaligned_seen    (unaligned_seen),
    .unmapped_seen     (unmapped_seen)
  );

  // Hard stop in case the block hangs or loses a response.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("[interrupt_enable_pending_priority_regs] ERROR");
      $finish;
    end
  end

  // Response ready. It changes only at falling edges. A long hold keeps it low
  // until the hold runs out; otherwise it stalls at the current rate.
  initial begin
    int hold_left;
    rsp.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_started != hold_requests) begin
        holds_started = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one request and returns at the falling edge after it was taken.
  // It is always entered just after a falling edge. Idle cycles are inserted
  // before the request; valid stays high from one request to the next when
  // no idle cycle falls between them.
  task automatic send_request(input logic op, input logic [11:0] off,
                              input logic [31:0] data, input logic [1:0] width);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.offset <= off;
    req.write_data <= data;
    req.access_width <= width;
    if (op == OP_READ) reads_sent++;
    else writes_sent++;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering requests until every response has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly well-formed accesses to the bit windows and the priority bytes, so
  // that reads find data written earlier; the rest is random noise.
  task automatic random_access();
    logic        op;
    logic [11:0] off;
    logic [31:0] data;
    logic [1:0]  width;
    int          pick;
    pick = $urandom_range(99);
    op = 1'($urandom_range(1));
    data = $urandom();
    if (pick < 40) begin
      case ($urandom_range(3))
        0: off = EN_SET_BASE;
        1: off = EN_CLR_BASE;
        2: off = PEND_SET_BASE;
        default: off = PEND_CLR_BASE;
      endcase
      off = off + 12'($urandom_range(31));
      width = ($urandom_range(9) == 0) ? 2'($urandom_range(2)) : WIDTH_WORD;
      // Thin out the data now and then so that sets and clears do not simply
      // saturate or empty the words.
      if ($urandom_range(1) == 1) data = data & $urandom();
    end else if (pick < 85) begin
      // Mostly inside the implemented bytes, a few past the last one.
      off = PRIO_BASE + 12'(($urandom_range(9) == 0) ? $urandom_range(511)
                                                      : $urandom_range(243));
      if (op == OP_WRITE) width = 2'($urandom_range(2));
      else width = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : WIDTH_WORD;
    end else begin
      off = 12'($urandom());
      width = 2'($urandom_range(3));
    end
    send_request(op, off, data, width);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = OP_READ;
    req.offset = '0;
    req.write_data = '0;
    req.access_width = WIDTH_WORD;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed accesses. Enable and pending: read of the reset value, set,
    // clear, and read-back through both windows, with the low offset bits set.
    send_request(OP_READ, EN_SET_BASE, 32'h0, WIDTH_WORD);
    send_request(OP_WRITE, EN_SET_BASE, 32'hFFFF_FFFF, WIDTH_WORD);
    send_request(OP_WRITE, EN_CLR_BASE, 32'h0000_FFFF, WIDTH_WORD);
    send_request(OP_READ, EN_CLR_BASE + 12'h3, 32'h0, WIDTH_WORD);
    send_request(OP_WRITE, PEND_SET_BASE + 12'h1C, 32'hA5A5_A5A5, WIDTH_WORD);
    send_request(OP_WRITE, PEND_CLR_BASE + 12'h1F, 32'h0000_00A5, WIDTH_WORD);
    send_request(OP_READ, PEND_SET_BASE + 12'h1C, 32'h0, WIDTH_WORD);
    send_request(OP_READ, PEND_CLR_BASE + 12'h1C, 32'h0, WIDTH_WORD);
    // Width errors come before the offset check, even at unmapped offsets.
    send_request(OP_READ, EN_SET_BASE, 32'h0, WIDTH_BYTE);
    send_request(OP_READ, 12'hFFF, 32'h0, WIDTH_HALF);
    send_request(OP_WRITE, EN_SET_BASE + 12'h4, 32'hFFFF_FFFF, WIDTH_HALF);
    send_request(OP_WRITE, PRIO_BASE, 32'hFFFF_FFFF, WIDTH_INVALID);
    send_request(OP_READ, PRIO_BASE, 32'h0, WIDTH_INVALID);
    // Offsets that map to nothing.
    send_request(OP_WRITE, 12'h200, 32'hFFFF_FFFF, WIDTH_WORD);
    send_request(OP_READ, 12'hFFF, 32'h0, WIDTH_WORD);
    // Priority bytes: all three widths, an unaligned half that spans two
    // words, a word that runs past the last interrupt, and one wholly beyond.
    send_request(OP_WRITE, PRIO_BASE, 32'h0102_0304, WIDTH_WORD);
    send_request(OP_WRITE, PRIO_BASE + 12'h5, 32'h0000_00FF, WIDTH_BYTE);
    send_request(OP_WRITE, PRIO_BASE + 12'h7, 32'h0000_BEEF, WIDTH_HALF);
    send_request(OP_WRITE, PRIO_BASE + 12'hEE, 32'hDEAD_BEEF, WIDTH_WORD);
    send_request(OP_WRITE, PRIO_END - 12'h1, 32'hFFFF_FFFF, WIDTH_WORD);
    send_request(OP_READ, PRIO_BASE, 32'h0, WIDTH_WORD);
    send_request(OP_READ, PRIO_BASE + 12'h6, 32'h0, WIDTH_WORD);
    send_request(OP_READ, PRIO_BASE + 12'hED, 32'h0, WIDTH_WORD);
    // Reads that start past the last implemented priority byte.
    send_request(OP_READ, PRIO_BASE + 12'hF0, 32'h0, WIDTH_WORD);
    send_request(OP_READ, PRIO_END - 12'h4, 32'h0, WIDTH_WORD);
    wait_drained();

    // Back-pressure: responses are held for a long stretch while requests keep
    // coming, so the block fills and stops taking requests.
    hold_requests++;
    repeat (HOLD_REQUESTS) random_access();
    wait_drained();

    // Random phases with different idle and stall mixes; the request side
    // pauses until all responses are back at the end of each phase.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct = 24;
        end
      endcase
      repeat (PHASE_ITEMS) random_access();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d reads and %0d writes under four idle and stall mixes and a long hold.",
             reads_sent, writes_sent);
    $display("Compared %0d responses: %0d unaligned and %0d unmapped among them.",
             responses_checked, unaligned_seen, unmapped_seen);
    if (failures == 0) begin
      $display("[interrupt_enable_pending_priority_regs] OK");
    end else begin
      $display("[interrupt_enable_pending_priority_regs] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/ippr_pkg.sv
src/ippr_if.sv
src/ippr_decode.sv
src/ippr_bit_mem.sv
src/ippr_prio_mem.sv
src/interrupt_enable_pending_priority_regs.sv
src/ippr_checker.sv
test/ippr_register_mirror.sv
test/interrupt_enable_pending_priority_regs_test.sv
